[src/fbsc_pkg.sv]
package fbsc_pkg;

  localparam int unsigned RegCount     = 6;
  localparam int unsigned PlaneSlots   = 8;
  localparam int unsigned PlaneCountDef = 6;
  localparam int unsigned RegIdxW      = 3;
  localparam int unsigned CoordW       = 24;
  localparam int unsigned ExtentW      = 23;
  localparam int unsigned NormW        = 14;
  localparam int unsigned OffsW        = 22;
  // Products of a centre coordinate with a normal, and their three-term sum.
  localparam int unsigned ProdW        = CoordW + NormW;
  localparam int unsigned DotW         = ProdW + 2;
  // Sum of three absolute normals fits 16 bits; times the radius gives 39.
  localparam int unsigned AbsSumW      = NormW + 2;
  localparam int unsigned EW           = ExtentW + AbsSumW;
  // Common compare width at scale 2^20, with headroom for sums.
  localparam int unsigned CmpW         = 44;

  typedef enum logic [1:0] {
    CLS_OUTSIDE    = 2'd0,
    CLS_INTERSECTS = 2'd1,
    CLS_INSIDE     = 2'd2
  } cls_e;

  typedef struct packed {
    logic signed [OffsW-1:0] d;
    logic signed [NormW-1:0] nz;
    logic signed [NormW-1:0] ny;
    logic signed [NormW-1:0] nx;
  } plane_t;

endpackage

[src/frustum_box_sphere_cull_core.sv]
// Frustum cull of axis-aligned boxes. Each input beat carries a box centre
// (signed Q15.8) and half-extents (unsigned Q15.8); the radius is the largest
// half-extent. A sphere and a cube of that radius are each tested against the
// stored planes (normals Q1.12, offsets Q13.8) and classed outside,
// intersecting or inside; the box is visible if either test is not outside or
// the ignore flag is set. The block takes one box per cycle while the output
// is not stalled; all planes are evaluated side by side in lanes, so without
// a stall throughput is one beat per clock regardless of the plane count. The
// pipeline is: input register, products of centre and normals plus radius
// search, dot sums and radius scaling, plane compares, class reduction into
// the output register. The whole pipe advances only when the output register
// is free or being emptied, so a stall holds every stage intact. Plane
// registers are written through the config channel; the user must write them
// only while the block is idle, which the block does not enforce. Indexes
// beyond the register list are ignored and planes beyond six read as zero.
module frustum_box_sphere_cull_core #(
  parameter int unsigned PLANE_COUNT = fbsc_pkg::PlaneCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: center_x[23:0], center_y[47:24], center_z[71:48], extent_x[94:72],
  // extent_y[117:95], extent_z[140:118], zero pad [143:141]
  input  logic [143:0] s_axis_tdata,
  // tuser: ignore_near
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: visible[0], sphere_class[2:1], cube_class[4:3], zero pad [7:5]
  output logic [7:0]  m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [fbsc_pkg::RegIdxW-1:0] cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import fbsc_pkg::*;

  localparam int unsigned Np = (PLANE_COUNT > PlaneSlots) ? PlaneSlots : PLANE_COUNT;

  // Plane registers.
  plane_t planes_q [RegCount];
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RegCount; i++) planes_q[i] <= '0;
    end else if (cfg_valid_i) begin
      for (int i = 0; i < RegCount; i++) begin
        if (cfg_index_i == RegIdxW'(i)) planes_q[i] <= plane_t'(cfg_data_i);
      end
    end
  end

  function automatic plane_t get_plane(input int i);
    plane_t p;
    p = '0;
    if (i < RegCount) p = planes_q[i];
    return p;
  endfunction

  logic adv;
  logic [4:0] v_q;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv) v_q <= {v_q[3:0], s_axis_tvalid};
  end
  assign m_axis_tvalid = v_q[4];

  // Stage 1: input register.
  logic signed [CoordW-1:0] c1_q [3];
  logic [ExtentW-1:0] e1_q [3];
  logic ign1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        c1_q[k] <= s_axis_tdata[k*CoordW +: CoordW];
        e1_q[k] <= s_axis_tdata[3*CoordW + k*ExtentW +: ExtentW];
      end
      ign1_q <= s_axis_tuser;
    end
  end

  // Stage 2: products and radius.
  logic signed [ProdW-1:0] p2_q [Np][3];
  logic [AbsSumW-1:0] a2_q [Np];
  logic signed [CmpW-1:0] d2_q [Np];
  logic [ExtentW-1:0] r2_q;
  logic ign2_q;
  logic [ExtentW-1:0] rmax;
  always_comb begin
    rmax = e1_q[0];
    if (e1_q[1] > rmax) rmax = e1_q[1];
    if (e1_q[2] > rmax) rmax = e1_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < Np; i++) begin
        plane_t p;
        logic [NormW-1:0] ax, ay, az;
        p = get_plane(i);
        ax = p.nx[NormW-1] ? NormW'(-p.nx) : p.nx;
        ay = p.ny[NormW-1] ? NormW'(-p.ny) : p.ny;
        az = p.nz[NormW-1] ? NormW'(-p.nz) : p.nz;
        p2_q[i][0] <= ProdW'(c1_q[0] * p.nx);
        p2_q[i][1] <= ProdW'(c1_q[1] * p.ny);
        p2_q[i][2] <= ProdW'(c1_q[2] * p.nz);
        a2_q[i] <= AbsSumW'(ax) + AbsSumW'(ay) + AbsSumW'(az);
        d2_q[i] <= {{(CmpW-OffsW-12){p.d[OffsW-1]}}, p.d, 12'd0};
      end
      r2_q <= rmax;
      ign2_q <= ign1_q;
    end
  end

  // Stage 3: dot sums, cube extent and scaled radius.
  logic signed [CmpW-1:0] dot3_q [Np];
  logic signed [CmpW-1:0] e3_q [Np];
  logic signed [CmpW-1:0] d3_q [Np];
  logic signed [CmpW-1:0] rs3_q;
  logic ign3_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < Np; i++) begin
        dot3_q[i] <= CmpW'(p2_q[i][0]) + CmpW'(p2_q[i][1]) + CmpW'(p2_q[i][2]);
        e3_q[i] <= CmpW'(r2_q * a2_q[i]);
        d3_q[i] <= d2_q[i];
      end
      rs3_q <= {{(CmpW-ExtentW-12){1'b0}}, r2_q, 12'd0};
      ign3_q <= ign2_q;
    end
  end

  // Stage 4: per-plane compares.
  logic [Np-1:0] so4_q, si4_q, co4_q, ci4_q;
  logic ign4_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < Np; i++) begin
        logic signed [CmpW-1:0] plane_dist;
        logic out_s;
        plane_dist = dot3_q[i] + d3_q[i];
        out_s = plane_dist < -rs3_q;
        so4_q[i] <= out_s;
        si4_q[i] <= !out_s && (plane_dist < rs3_q) && (-plane_dist < rs3_q);
        co4_q[i] <= (dot3_q[i] + e3_q[i]) < -d3_q[i];
        ci4_q[i] <= (dot3_q[i] - e3_q[i]) < -d3_q[i];
      end
      ign4_q <= ign3_q;
    end
  end

  // Stage 5: class reduction into the output register.
  cls_e scls, ccls, scls_q, ccls_q;
  logic vis_q;
  always_comb begin
    scls = (|so4_q) ? CLS_OUTSIDE : ((|si4_q) ? CLS_INTERSECTS : CLS_INSIDE);
    ccls = (|co4_q) ? CLS_OUTSIDE : ((|ci4_q) ? CLS_INTERSECTS : CLS_INSIDE);
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      scls_q <= scls;
      ccls_q <= ccls;
      vis_q <= ign4_q || (scls != CLS_OUTSIDE) || (ccls != CLS_OUTSIDE);
    end
  end
  assign m_axis_tdata = {3'b000, ccls_q, scls_q, vis_q};

  // A held result stays stable while stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output changed under stall");
  // The input side is stalled exactly when a result is held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready does not follow output stall");
  // An outside verdict from both tests is invisible unless ignored.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:1] == CLS_OUTSIDE && m_axis_tdata[4:3] == CLS_OUTSIDE
    && !$past(ign4_q) && $past(adv) |-> !m_axis_tdata[0])
    else $error("visible flag inconsistent with classes");
endmodule
